@@ rtl/core/ebim_pkg.sv @@
`default_nettype none

package ebim_pkg;

  // Operation codes carried in each input transaction.
  localparam logic OP_SEEK    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Indirection depth codes.
  localparam logic [1:0] DEPTH_DIRECT = 2'd0;
  localparam logic [1:0] DEPTH_SINGLE = 2'd1;
  localparam logic [1:0] DEPTH_DOUBLE = 2'd2;
  localparam logic [1:0] DEPTH_TRIPLE = 2'd3;

  // Fixed field widths.
  localparam int POS_W   = 36;
  localparam int SLOT_W  = 4;
  localparam int INDEX_W = 8;

  typedef struct packed {
    logic             operation;
    logic [POS_W-1:0] byte_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         depth;
    logic [SLOT_W-1:0]  inode_slot;
    logic [INDEX_W-1:0] level1_index;
    logic [INDEX_W-1:0] level2_index;
    logic [INDEX_W-1:0] level3_index;
    logic [POS_W-1:0]   block_position;
    logic               out_of_range;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/ebim_stream_if.sv @@
`default_nettype none

interface ebim_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

@@ rtl/core/ext2_block_index_mapper_top.sv @@
`default_nettype none

// Channel  Role    Payload     Contents
// req      sink    in_item_t   operation (seek / advance), byte_offset
// rsp      source  out_item_t  depth, inode_slot, level indices, block_position, out_of_range
//
// One transaction is accepted per cycle while req.ready is high; each gives one result
// through the input register, then the mapping logic into the result register.
// The path state is updated by the same edge that loads the result register,
// so consecutive transactions see each other's effects with no gap.
// A stalled rsp holds the result register; req keeps flowing while the input
// register is empty or moving. Reset (rst, synchronous) clears the path to
// direct slot 0 at position 0 and drops both valid flags.

module ext2_block_index_mapper_top #(
  parameter int BLOCK_BYTES_LOG2 = 10,
  parameter int ENTRIES_LOG2     = 8,
  parameter int DIRECT_SLOTS     = 12
) (
  input wire logic     clk,
  input wire logic     rst,
  ebim_stream_if.sink   req,
  ebim_stream_if.source rsp
);

  import ebim_pkg::*;

  localparam int B     = BLOCK_BYTES_LOG2;
  localparam int E     = ENTRIES_LOG2;
  localparam int LIM_W = B + 3 * E + 2;

  // Region limits of the byte offset space.
  localparam logic [LIM_W-1:0] DIRECT_LIM = LIM_W'(DIRECT_SLOTS) << B;
  localparam logic [LIM_W-1:0] SINGLE_LIM = DIRECT_LIM + (LIM_W'(1) << (B + E));
  localparam logic [LIM_W-1:0] DOUBLE_LIM = SINGLE_LIM + (LIM_W'(1) << (B + 2 * E));
  localparam logic [LIM_W-1:0] TRIPLE_LIM = DOUBLE_LIM + (LIM_W'(1) << (B + 3 * E));

  localparam logic [POS_W-1:0]  BLOCK_STEP = POS_W'(1) << B;
  localparam logic [POS_W-1:0]  ALIGN_MASK = ~(BLOCK_STEP - POS_W'(1));
  localparam logic [E-1:0]      IDX_MAX    = '1;
  localparam logic [SLOT_W-1:0] FIRST_IND  = SLOT_W'(DIRECT_SLOTS);
  localparam logic [SLOT_W-1:0] LAST_DIR   = SLOT_W'(DIRECT_SLOTS - 1);

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;

  // Result register.
  logic      res_valid;
  out_item_t res;

  // Path state.
  logic [1:0]        cur_depth;
  logic [SLOT_W-1:0] slot_index;
  logic [E-1:0]      idx0;
  logic [E-1:0]      idx1;
  logic [E-1:0]      idx2;
  logic [POS_W-1:0]  cur_position;

  logic [1:0]        cur_depth_next;
  logic [SLOT_W-1:0] slot_index_next;
  logic [E-1:0]      idx0_next;
  logic [E-1:0]      idx1_next;
  logic [E-1:0]      idx2_next;
  logic [POS_W-1:0]  cur_position_next;
  logic              refused;

  logic out_adv;
  logic in_ready;

  logic [LIM_W-1:0] off_ext;
  logic [LIM_W-1:0] rem_single;
  logic [LIM_W-1:0] rem_double;
  logic [LIM_W-1:0] rem_triple;
  logic [E-1:0]     inc0;
  logic [E-1:0]     inc1;
  logic [E-1:0]     inc2;
  logic             m0;
  logic             m1;
  logic             m2;
  logic             all_max;

  assign out_adv  = !res_valid || rsp.ready;
  assign in_ready = !s1_valid || out_adv;

  assign req.ready   = in_ready;
  assign rsp.valid   = res_valid;
  assign rsp.payload = res;

  // Offset remainders inside each indirect region.
  assign off_ext    = LIM_W'(s1_item.byte_offset);
  assign rem_single = off_ext - SINGLE_LIM + (SINGLE_LIM - DIRECT_LIM);
  assign rem_double = off_ext - SINGLE_LIM;
  assign rem_triple = off_ext - DOUBLE_LIM;

  // Carry chain terms for advance.
  assign inc0 = idx0 + E'(1);
  assign inc1 = idx1 + E'(1);
  assign inc2 = idx2 + E'(1);
  assign m0   = (idx0 == IDX_MAX);
  assign m1   = (idx1 == IDX_MAX);
  assign m2   = (idx2 == IDX_MAX);

  always_comb begin
    unique case (cur_depth)
      DEPTH_SINGLE: all_max = m0;
      DEPTH_DOUBLE: all_max = m0 && m1;
      DEPTH_TRIPLE: all_max = m0 && m1 && m2;
      default:      all_max = 1'b0;
    endcase
  end

  // Next path state for the item in the input register.
  always_comb begin
    cur_depth_next    = cur_depth;
    slot_index_next   = slot_index;
    idx0_next         = idx0;
    idx1_next         = idx1;
    idx2_next         = idx2;
    cur_position_next = cur_position;
    refused           = 1'b0;

    if (s1_item.operation == OP_SEEK) begin
      priority if (off_ext >= TRIPLE_LIM) begin
        refused = 1'b1;
      end else if (off_ext < DIRECT_LIM) begin
        cur_depth_next  = DEPTH_DIRECT;
        slot_index_next = off_ext[B +: SLOT_W];
        idx0_next       = '0;
        idx1_next       = '0;
        idx2_next       = '0;
      end else if (off_ext < SINGLE_LIM) begin
        cur_depth_next  = DEPTH_SINGLE;
        slot_index_next = FIRST_IND;
        idx0_next       = rem_single[B +: E];
        idx1_next       = '0;
        idx2_next       = '0;
      end else if (off_ext < DOUBLE_LIM) begin
        cur_depth_next  = DEPTH_DOUBLE;
        slot_index_next = FIRST_IND + SLOT_W'(1);
        idx0_next       = rem_double[B + E +: E];
        idx1_next       = rem_double[B +: E];
        idx2_next       = '0;
      end else begin
        cur_depth_next  = DEPTH_TRIPLE;
        slot_index_next = FIRST_IND + SLOT_W'(2);
        idx0_next       = rem_triple[B + 2 * E +: E];
        idx1_next       = rem_triple[B + E +: E];
        idx2_next       = rem_triple[B +: E];
      end
      if (!refused) begin
        cur_position_next = s1_item.byte_offset & ALIGN_MASK;
      end
    end else begin
      // Advance: step the deepest in-use index and ripple the carry upward.
      unique case (cur_depth)
        DEPTH_DIRECT: begin
          if (slot_index >= LAST_DIR) begin
            cur_depth_next  = DEPTH_SINGLE;
            slot_index_next = FIRST_IND;
            idx0_next       = '0;
            idx1_next       = '0;
            idx2_next       = '0;
          end else begin
            slot_index_next = slot_index + SLOT_W'(1);
          end
        end
        DEPTH_SINGLE: begin
          idx0_next = m0 ? '0 : inc0;
        end
        DEPTH_DOUBLE: begin
          idx1_next = m1 ? '0 : inc1;
          idx0_next = m1 ? (m0 ? '0 : inc0) : idx0;
        end
        default: begin
          idx2_next = m2 ? '0 : inc2;
          idx1_next = m2 ? (m1 ? '0 : inc1) : idx1;
          idx0_next = (m2 && m1) ? (m0 ? '0 : inc0) : idx0;
        end
      endcase

      // A used-up level moves into the next depth, or is refused at triple.
      if (all_max) begin
        if (cur_depth == DEPTH_TRIPLE) begin
          refused   = 1'b1;
          idx0_next = idx0;
          idx1_next = idx1;
          idx2_next = idx2;
        end else begin
          cur_depth_next  = cur_depth + 2'd1;
          slot_index_next = slot_index + SLOT_W'(1);
          idx0_next       = '0;
          idx1_next       = '0;
          idx2_next       = '0;
        end
      end

      if (!refused) begin
        cur_position_next = cur_position + BLOCK_STEP;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= req.valid;
    end
    if (in_ready && req.valid) begin
      s1_item <= req.payload;
    end
  end

  // Result register and path state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid    <= 1'b0;
      cur_depth    <= DEPTH_DIRECT;
      slot_index   <= '0;
      idx0         <= '0;
      idx1         <= '0;
      idx2         <= '0;
      cur_position <= '0;
    end else if (out_adv) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        cur_depth    <= cur_depth_next;
        slot_index   <= slot_index_next;
        idx0         <= idx0_next;
        idx1         <= idx1_next;
        idx2         <= idx2_next;
        cur_position <= cur_position_next;
      end
    end
    if (out_adv && s1_valid) begin
      res.depth          <= cur_depth_next;
      res.inode_slot     <= slot_index_next;
      res.level1_index   <= idx0_next[INDEX_W-1:0];
      res.level2_index   <= idx1_next[INDEX_W-1:0];
      res.level3_index   <= idx2_next[INDEX_W-1:0];
      res.block_position <= cur_position_next;
      res.out_of_range   <= refused;
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/ebim_checker.sv @@
`default_nettype none

// Watches both channels of the block-index mapper, predicts each result from the
// accepted request transactions and compares the response transactions in order.
module ebim_checker
  import ebim_pkg::*;
#(
  parameter int BLOCK_BYTES_LOG2 = 10,
  parameter int ENTRIES_LOG2     = 8,
  parameter int DIRECT_SLOTS     = 12
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  input  wire logic      req_ready,
  input  wire in_item_t  req_payload,
  input  wire logic      rsp_valid,
  input  wire logic      rsp_ready,
  input  wire out_item_t rsp_payload,
  output int             fail_count,
  output int             outstanding
);

  timeunit 1ns;
  timeprecision 1ps;

  // Byte limits of each indirection range.
  localparam logic [63:0] BLOCK_BYTES = 64'd1 << BLOCK_BYTES_LOG2;
  localparam logic [63:0] DIRECT_END = 64'(DIRECT_SLOTS) << BLOCK_BYTES_LOG2;
  localparam logic [63:0] SINGLE_END =
    DIRECT_END + (64'd1 << (BLOCK_BYTES_LOG2 + ENTRIES_LOG2));
  localparam logic [63:0] DOUBLE_END =
    SINGLE_END + (64'd1 << (BLOCK_BYTES_LOG2 + 2 * ENTRIES_LOG2));
  localparam logic [63:0] TRIPLE_END =
    DOUBLE_END + (64'd1 << (BLOCK_BYTES_LOG2 + 3 * ENTRIES_LOG2));
  localparam logic [15:0] INDEX_MAX = 16'((64'd1 << ENTRIES_LOG2) - 64'd1);

  // Predicted block-pointer path.
  logic [1:0]       path_depth;
  logic [3:0]       path_slot;
  logic [15:0]      path_index [3];
  logic [POS_W-1:0] path_pos;

  out_item_t expected_paths [$];
  int        mismatches;
  int        result_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch on result %0d: %s", $realtime, result_count, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Applies one request to the predicted path and returns the result it gives.
  task automatic map_transaction(input in_item_t item, output out_item_t res);
    logic        refused;
    logic [63:0] off;
    logic [63:0] rem;
    logic [15:0] idx [3];
    logic        carry;
    int          lvl;
    refused = 1'b0;
    if (item.operation == OP_SEEK) begin
      off = 64'(item.byte_offset);
      if (off >= TRIPLE_END) begin
        refused = 1'b1;
      end else begin
        path_index[0] = '0;
        path_index[1] = '0;
        path_index[2] = '0;
        if (off < DIRECT_END) begin
          path_depth = DEPTH_DIRECT;
          path_slot  = 4'(off >> BLOCK_BYTES_LOG2);
        end else if (off < SINGLE_END) begin
          rem           = off - DIRECT_END;
          path_depth    = DEPTH_SINGLE;
          path_slot     = 4'(DIRECT_SLOTS);
          path_index[0] = 16'(rem >> BLOCK_BYTES_LOG2) & INDEX_MAX;
        end else if (off < DOUBLE_END) begin
          rem           = off - SINGLE_END;
          path_depth    = DEPTH_DOUBLE;
          path_slot     = 4'(DIRECT_SLOTS + 1);
          path_index[0] = 16'(rem >> (BLOCK_BYTES_LOG2 + ENTRIES_LOG2)) & INDEX_MAX;
          path_index[1] = 16'(rem >> BLOCK_BYTES_LOG2) & INDEX_MAX;
        end else begin
          // The triple range counts from the end of the double range.
          rem           = off - DOUBLE_END;
          path_depth    = DEPTH_TRIPLE;
          path_slot     = 4'(DIRECT_SLOTS + 2);
          path_index[0] = 16'(rem >> (BLOCK_BYTES_LOG2 + 2 * ENTRIES_LOG2)) & INDEX_MAX;
          path_index[1] = 16'(rem >> (BLOCK_BYTES_LOG2 + ENTRIES_LOG2)) & INDEX_MAX;
          path_index[2] = 16'(rem >> BLOCK_BYTES_LOG2) & INDEX_MAX;
        end
        path_pos = POS_W'((off >> BLOCK_BYTES_LOG2) << BLOCK_BYTES_LOG2);
      end
    end else if (path_depth == DEPTH_DIRECT) begin
      // Leaving the last direct slot enters the single indirect block at entry 0.
      if (int'(path_slot) >= DIRECT_SLOTS - 1) begin
        path_depth    = DEPTH_SINGLE;
        path_slot     = 4'(DIRECT_SLOTS);
        path_index[0] = '0;
        path_index[1] = '0;
        path_index[2] = '0;
      end else begin
        path_slot = path_slot + 4'd1;
      end
      path_pos = path_pos + POS_W'(BLOCK_BYTES);
    end else begin
      // Carry from the deepest level upward; a full carry promotes the depth, or is refused at triple.
      idx[0] = path_index[0];
      idx[1] = path_index[1];
      idx[2] = path_index[2];
      carry  = 1'b1;
      for (lvl = int'(path_depth); lvl >= 1 && carry; lvl--) begin
        if (idx[lvl-1] >= INDEX_MAX) begin
          idx[lvl-1] = '0;
        end else begin
          idx[lvl-1] = idx[lvl-1] + 16'd1;
          carry      = 1'b0;
        end
      end
      if (carry && path_depth == DEPTH_TRIPLE) begin
        refused = 1'b1;
      end else begin
        if (carry) begin
          path_depth = path_depth + 2'd1;
          path_slot  = path_slot + 4'd1;
          idx[0]     = '0;
          idx[1]     = '0;
          idx[2]     = '0;
        end
        path_index[0] = idx[0];
        path_index[1] = idx[1];
        path_index[2] = idx[2];
        path_pos      = path_pos + POS_W'(BLOCK_BYTES);
      end
    end
    res.depth          = path_depth;
    res.inode_slot     = path_slot;
    res.level1_index   = path_index[0][INDEX_W-1:0];
    res.level2_index   = path_index[1][INDEX_W-1:0];
    res.level3_index   = path_index[2][INDEX_W-1:0];
    res.block_position = path_pos;
    res.out_of_range   = refused;
  endtask

  // Predict on each request transaction, compare on each response transaction.
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      path_depth    = DEPTH_DIRECT;
      path_slot     = '0;
      path_index[0] = '0;
      path_index[1] = '0;
      path_index[2] = '0;
      path_pos      = '0;
      expected_paths.delete();
      mismatches    = 0;
      result_count  = 0;
    end else begin
      if (req_valid && req_ready) begin
        map_transaction(req_payload, want);
        expected_paths.push_back(want);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_paths.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, position %0h",
                                    rsp_payload.block_position));
        end else begin
          want = expected_paths.pop_front();
          check_field("depth", 64'(rsp_payload.depth), 64'(want.depth));
          check_field("inode_slot", 64'(rsp_payload.inode_slot), 64'(want.inode_slot));
          check_field("level1_index", 64'(rsp_payload.level1_index),
                      64'(want.level1_index));
          check_field("level2_index", 64'(rsp_payload.level2_index),
                      64'(want.level2_index));
          check_field("level3_index", 64'(rsp_payload.level3_index),
                      64'(want.level3_index));
          check_field("block_position", 64'(rsp_payload.block_position),
                      64'(want.block_position));
          check_field("out_of_range", 64'(rsp_payload.out_of_range),
                      64'(want.out_of_range));
        end
        result_count++;
      end
    end
    outstanding <= expected_paths.size();
    fail_count  <= mismatches;
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none

module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import ebim_pkg::*;

  localparam int BLOCK_LOG2  = 10;
  localparam int INDEX_LOG2  = 8;
  localparam int NUM_DIRECT  = 12;
  localparam int ITEM_TARGET = 1900;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam logic [63:0] BLOCK_BYTES = 64'd1 << BLOCK_LOG2;
  localparam logic [63:0] DIRECT_END = 64'(NUM_DIRECT) << BLOCK_LOG2;
  localparam logic [63:0] SINGLE_END = DIRECT_END + (64'd1 << (BLOCK_LOG2 + INDEX_LOG2));
  localparam logic [63:0] DOUBLE_END =
    SINGLE_END + (64'd1 << (BLOCK_LOG2 + 2 * INDEX_LOG2));
  localparam logic [63:0] TRIPLE_END =
    DOUBLE_END + (64'd1 << (BLOCK_LOG2 + 3 * INDEX_LOG2));
  localparam int INDEX_TOP = (1 << INDEX_LOG2) - 1;

  logic clk;
  logic rst;
  logic hold_off_req;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   burst_left;
  int   item_count;
  bit   no_gaps;

  ebim_stream_if #(.payload_t(in_item_t))  req_if ();
  ebim_stream_if #(.payload_t(out_item_t)) rsp_if ();

  ext2_block_index_mapper_top #(
    .BLOCK_BYTES_LOG2(BLOCK_LOG2),
    .ENTRIES_LOG2    (INDEX_LOG2),
    .DIRECT_SLOTS    (NUM_DIRECT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  ebim_checker #(
    .BLOCK_BYTES_LOG2(BLOCK_LOG2),
    .ENTRIES_LOG2    (INDEX_LOG2),
    .DIRECT_SLOTS    (NUM_DIRECT)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_if.valid),
    .req_ready  (req_if.ready),
    .req_payload(req_if.payload),
    .rsp_valid  (rsp_if.valid),
    .rsp_ready  (rsp_if.ready),
    .rsp_payload(rsp_if.payload),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Response side: stall modes of random length, plus one long hold-off on request.
  initial begin : receiver
    int  mode_left;
    int  stall_pct;
    int  hold_left;
    bit  hold_served;
    rsp_if.ready = 1'b0;
    mode_left    = 0;
    stall_pct    = 0;
    hold_left    = 0;
    hold_served  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [POS_W-1:0] rand_offset();
    return POS_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t seek_item(input logic [63:0] off);
    in_item_t item;
    item.operation   = OP_SEEK;
    item.byte_offset = POS_W'(off);
    return item;
  endfunction

  function automatic in_item_t advance_item();
    in_item_t item;
    item.operation   = OP_ADVANCE;
    item.byte_offset = rand_offset();
    return item;
  endfunction

  // Index values lean toward the last entry so that carries and promotions happen.
  function automatic logic [63:0] pick_index();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return 64'(INDEX_TOP);
    end else if (roll == 4) begin
      return 64'd0;
    end
    return 64'($urandom_range(0, INDEX_TOP));
  endfunction

  // Offers one request transaction, in bursts separated by random gaps unless no_gaps is set.
  task automatic offer(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0 && !no_gaps) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid   <= 1'b1;
    req_if.payload <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    item_count++;
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // A seek into a chosen depth followed by a run of advances.
  task automatic path_walk();
    logic [63:0] off;
    logic [63:0] low;
    int          run;
    low = 64'($urandom_range(0, int'(BLOCK_BYTES) - 1));
    case ($urandom_range(0, 3))
      0: begin
        off = ($urandom_range(0, 1) == 1) ? 64'(NUM_DIRECT - 1)
                                          : 64'($urandom_range(0, NUM_DIRECT - 1));
        off = (off << BLOCK_LOG2) + low;
      end
      1: off = DIRECT_END + (pick_index() << BLOCK_LOG2) + low;
      2: off = SINGLE_END + (pick_index() << (BLOCK_LOG2 + INDEX_LOG2))
               + (pick_index() << BLOCK_LOG2) + low;
      default: off = DOUBLE_END + (pick_index() << (BLOCK_LOG2 + 2 * INDEX_LOG2))
                     + (pick_index() << (BLOCK_LOG2 + INDEX_LOG2))
                     + (pick_index() << BLOCK_LOG2) + low;
    endcase
    offer(seek_item(off));
    run = $urandom_range(1, 24);
    repeat (run) offer(advance_item());
  endtask

  initial begin : stimulus
    int kind;
    rst            = 1'b1;
    hold_off_req   = 1'b0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    burst_left     = 0;
    item_count     = 0;
    no_gaps        = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: region edges, promotions, refusals and carries.
    offer(advance_item());
    offer(seek_item(64'd0));
    offer(seek_item(DIRECT_END - 1));
    offer(advance_item());
    offer(seek_item(SINGLE_END - 1));
    offer(advance_item());
    offer(seek_item(DOUBLE_END - 1));
    offer(advance_item());
    offer(seek_item(TRIPLE_END - 1));
    offer(advance_item());
    offer(advance_item());
    offer(seek_item(TRIPLE_END));
    offer(seek_item(64'hF_FFFF_FFFF));
    offer(seek_item(SINGLE_END + (64'd5 << (BLOCK_LOG2 + INDEX_LOG2))
                    + (64'(INDEX_TOP) << BLOCK_LOG2) + 64'd777));
    offer(advance_item());
    offer(seek_item(DOUBLE_END + (64'd3 << (BLOCK_LOG2 + 2 * INDEX_LOG2))
                    + (64'(INDEX_TOP) << (BLOCK_LOG2 + INDEX_LOG2))
                    + (64'(INDEX_TOP) << BLOCK_LOG2)));
    offer(advance_item());
    offer(seek_item(DIRECT_END));
    offer(seek_item(SINGLE_END));
    offer(seek_item(DOUBLE_END));
    offer(seek_item(BLOCK_BYTES - 1));
    offer(seek_item(64'h2_AAAA_AAAA));
    offer(seek_item(64'h5_5555_5555));
    offer(advance_item());
    wait_drained();

    // Random: mostly seek-and-walk sequences, some raw noise.
    while (item_count < ITEM_TARGET) begin
      if (item_count >= 800 && !hold_off_req) begin
        // Keep offering back to back while the response side holds off.
        hold_off_req <= 1'b1;
        no_gaps = 1'b1;
        repeat (50) path_walk();
        no_gaps = 1'b0;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        offer(seek_item(64'(rand_offset())));
      end else if (kind == 1) begin
        repeat ($urandom_range(1, 10)) offer(advance_item());
      end else begin
        path_walk();
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
